FILE: design/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define RAP_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define RAP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types, constants and tables of the ring armor position pipeline.
// ----------------------------------------------------------------------------
package rap_pkg;

	localparam int DATA_IN_W  = 232;
	localparam int DATA_OUT_W = 136;
	localparam int ANG_W      = 34;
	localparam int XY_W       = 34;
	localparam int ITERS      = 28;

	localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd843314857;
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] ANG_FOUR_PI = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd421657428;
	localparam logic signed [XY_W-1:0]  CORDIC_K    = 34'sd652032874;

	// Per-plate data that rides along with the angle.
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] z;
		logic signed [31:0] r;
		logic signed [30:0] ang;
		logic [2:0]         idx;
		logic               last;
	} side_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Arctangent of 2^-i in Q3.28.
	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:    a = 32'd210828714;
			5'd1:    a = 32'd124459457;
			5'd2:    a = 32'd65760959;
			5'd3:    a = 32'd33381290;
			5'd4:    a = 32'd16755422;
			5'd5:    a = 32'd8385879;
			5'd6:    a = 32'd4193963;
			5'd7:    a = 32'd2097109;
			5'd8:    a = 32'd1048571;
			5'd9:    a = 32'd524287;
			default: a = 32'd1 << (5'd28 - i);
		endcase
		return a;
	endfunction

	// Whole part of 2pi / count.
	function automatic logic [31:0] step_quot(input logic [4:0] c);
		logic [31:0] q;
		unique case (c)
			5'd1:    q = 32'd1686629713;
			5'd2:    q = 32'd843314856;
			5'd3:    q = 32'd562209904;
			5'd4:    q = 32'd421657428;
			5'd5:    q = 32'd337325942;
			5'd6:    q = 32'd281104952;
			5'd7:    q = 32'd240947101;
			5'd8:    q = 32'd210828714;
			5'd9:    q = 32'd187403301;
			5'd10:   q = 32'd168662971;
			5'd11:   q = 32'd153329973;
			5'd12:   q = 32'd140552476;
			5'd13:   q = 32'd129740747;
			5'd14:   q = 32'd120473550;
			5'd15:   q = 32'd112441980;
			5'd16:   q = 32'd105414357;
			default: q = 32'd0;
		endcase
		return q;
	endfunction

	// Remainder of 2pi / count.
	function automatic logic [4:0] step_rem(input logic [4:0] c);
		logic [4:0] r;
		unique case (c)
			5'd5, 5'd10:  r = 5'd3;
			5'd7:         r = 5'd6;
			5'd9:         r = 5'd4;
			5'd11:        r = 5'd10;
			5'd13:        r = 5'd2;
			5'd14, 5'd15: r = 5'd13;
			5'd1:         r = 5'd0;
			default:      r = 5'd1;
		endcase
		return r;
	endfunction

endpackage

FILE: design/rap_issue.sv
// ----------------------------------------------------------------------------
// rap_issue
// Holds one target and hands out one plate per cycle while en is high, with its raw angle.
// ----------------------------------------------------------------------------
module rap_issue #(
	parameter int MAX_ARMORS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rap_pkg::DATA_IN_W-1:0]      s_tdata,
	output logic                               valid_s1,
	output rap_pkg::side_t                     side_s1,
	output logic signed [rap_pkg::ANG_W-1:0]   ang_s1
);

	localparam int CW = $clog2(MAX_ARMORS + 1);

	logic             busy_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    cnt_q;
	logic [31:0]      step_q;
	logic [CW:0]      rem_q;
	logic signed [31:0] cx_q, cy_q, cz_q, hz_q, rb_q, ra_q;
	logic signed [30:0] yaw_q;

	logic [3:0]       cnt_in;
	logic [CW-1:0]    cnt_cl;
	logic [CW:0]      rem_sum;
	logic             carry;
	logic             alt;
	logic             is_last;

	assign s_tready = !busy_q;
	assign cnt_in   = s_tdata[226:223];

	// Clamp the count to the ring size.
	always_comb begin
		if (32'(cnt_in) > 32'(MAX_ARMORS)) begin
			cnt_cl = CW'(MAX_ARMORS);
		end else begin
			cnt_cl = CW'(cnt_in);
		end
	end

	// Next step: add 2pi/count with its remainder carried.
	assign rem_sum = rem_q + (CW+1)'(rap_pkg::step_rem(5'(cnt_q)));
	assign carry   = rem_sum >= (CW+1)'(cnt_q);
	assign alt     = (cnt_q == CW'(4)) && k_q[0];
	assign is_last = (k_q + CW'(1)) == cnt_q;

	// Target registers and plate counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			cnt_q  <= '0;
			step_q <= '0;
			rem_q  <= '0;
		end else if (s_tvalid && s_tready) begin
			busy_q <= cnt_cl != '0;
			k_q    <= '0;
			cnt_q  <= cnt_cl;
			step_q <= '0;
			rem_q  <= (CW+1)'(cnt_cl >> 1);
		end else if (busy_q && en) begin
			k_q    <= k_q + CW'(1);
			step_q <= step_q + rap_pkg::step_quot(5'(cnt_q)) + 32'(carry);
			rem_q  <= carry ? rem_sum - (CW+1)'(cnt_q) : rem_sum;
			if (is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Field capture with the sums for the odd plates of a four-plate ring worked out once.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cx_q  <= s_tdata[31:0];
			cy_q  <= s_tdata[63:32];
			cz_q  <= s_tdata[95:64];
			yaw_q <= s_tdata[126:96];
			rb_q  <= s_tdata[158:127];
			ra_q  <= rap_pkg::sat32(40'(signed'(s_tdata[158:127]))
				+ 40'(signed'(s_tdata[190:159])));
			hz_q  <= rap_pkg::sat32(40'(signed'(s_tdata[95:64]))
				+ 40'(signed'(s_tdata[222:191])));
		end
	end

	// First pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.cx   <= cx_q;
			side_s1.cy   <= cy_q;
			side_s1.z    <= alt ? hz_q : cz_q;
			side_s1.r    <= alt ? ra_q : rb_q;
			side_s1.ang  <= '0;
			side_s1.idx  <= 3'(k_q);
			side_s1.last <= is_last;
			ang_s1       <= rap_pkg::ANG_W'(yaw_q) + signed'({2'b00, step_q});
		end
	end

endmodule

FILE: design/rap_cordic.sv
// ----------------------------------------------------------------------------
// rap_cordic
// Wraps the angle into [-pi, pi) and runs a 28-stage rotation CORDIC.
// ----------------------------------------------------------------------------
module rap_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_in,
	input  rap_pkg::side_t                    side_in,
	input  logic signed [rap_pkg::ANG_W-1:0]  ang_in,
	output logic                              valid_out,
	output rap_pkg::side_t                    side_out,
	output logic                              neg_out,
	output logic signed [rap_pkg::XY_W-1:0]   x_out,
	output logic signed [rap_pkg::XY_W-1:0]   y_out
);

	localparam int N = rap_pkg::ITERS;
	localparam int PRE = 5;

	logic                            v_pre  [0:PRE-1];
	rap_pkg::side_t                  sd_pre [0:PRE-1];
	logic signed [rap_pkg::ANG_W-1:0] t_pre [0:PRE-2];

	logic                            v_sn   [0:N];
	rap_pkg::side_t                  sd_sn  [0:N];
	logic                            neg_sn [0:N];
	logic signed [rap_pkg::XY_W-1:0] x_sn   [0:N];
	logic signed [rap_pkg::XY_W-1:0] y_sn   [0:N];
	logic signed [31:0]              z_sn   [0:N];

	logic signed [rap_pkg::ANG_W-1:0] ang_w;
	rap_pkg::side_t                   sd_wrap;

	assign ang_w = t_pre[3] - rap_pkg::ANG_PI;

	// Side data of the last wrap stage picks up the wrapped angle.
	always_comb begin
		sd_wrap     = sd_pre[PRE-2];
		sd_wrap.ang = ang_w[30:0];
	end

	// Valid bits of the wrap stages and the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRE; i++) v_pre[i] <= 1'b0;
			for (int i = 0; i <= N; i++) v_sn[i] <= 1'b0;
		end else if (en) begin
			v_pre[0] <= valid_in;
			for (int i = 1; i < PRE; i++) v_pre[i] <= v_pre[i-1];
			v_sn[0] <= v_pre[PRE-1];
			for (int i = 1; i <= N; i++) v_sn[i] <= v_sn[i-1];
		end
	end

	// Wrap: shift by pi, fold negatives up, take off 2pi or 4pi, shift back.
	always_ff @(posedge clk) begin
		if (en) begin
			sd_pre[0] <= side_in;
			for (int i = 1; i < PRE-1; i++) sd_pre[i] <= sd_pre[i-1];
			t_pre[0] <= ang_in + rap_pkg::ANG_PI;
			t_pre[1] <= (t_pre[0] < 0) ? t_pre[0] + rap_pkg::ANG_TWO_PI : t_pre[0];
			if (t_pre[1] >= rap_pkg::ANG_FOUR_PI) begin
				t_pre[2] <= t_pre[1] - rap_pkg::ANG_FOUR_PI;
			end else if (t_pre[1] >= rap_pkg::ANG_TWO_PI) begin
				t_pre[2] <= t_pre[1] - rap_pkg::ANG_TWO_PI;
			end else begin
				t_pre[2] <= t_pre[1];
			end
			t_pre[3] <= t_pre[2];
			sd_pre[PRE-1] <= sd_wrap;
		end
	end

	// Fold the angle into the right half plane.
	always_ff @(posedge clk) begin
		if (en) begin
			sd_sn[0] <= sd_pre[PRE-1];
			x_sn[0]  <= rap_pkg::CORDIC_K;
			y_sn[0]  <= '0;
			priority if (32'(sd_pre[PRE-1].ang) > 32'(rap_pkg::ANG_HALF_PI)) begin
				z_sn[0]   <= 32'(sd_pre[PRE-1].ang) - 32'(rap_pkg::ANG_PI);
				neg_sn[0] <= 1'b1;
			end else if (32'(sd_pre[PRE-1].ang) < -32'(rap_pkg::ANG_HALF_PI)) begin
				z_sn[0]   <= 32'(sd_pre[PRE-1].ang) + 32'(rap_pkg::ANG_PI);
				neg_sn[0] <= 1'b1;
			end else begin
				z_sn[0]   <= 32'(sd_pre[PRE-1].ang);
				neg_sn[0] <= 1'b0;
			end
		end
	end

	// One rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [rap_pkg::XY_W-1:0] dx, dy;
		logic signed [31:0]              at;
		assign dx = y_sn[i] >>> i;
		assign dy = x_sn[i] >>> i;
		assign at = signed'(rap_pkg::atan_at(5'(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				sd_sn[i+1]  <= sd_sn[i];
				neg_sn[i+1] <= neg_sn[i];
				if (z_sn[i] >= 0) begin
					x_sn[i+1] <= x_sn[i] - dx;
					y_sn[i+1] <= y_sn[i] + dy;
					z_sn[i+1] <= z_sn[i] - at;
				end else begin
					x_sn[i+1] <= x_sn[i] + dx;
					y_sn[i+1] <= y_sn[i] - dy;
					z_sn[i+1] <= z_sn[i] + at;
				end
			end
		end
	end

	assign valid_out = v_sn[N];
	assign side_out  = sd_sn[N];
	assign neg_out   = neg_sn[N];
	assign x_out     = x_sn[N];
	assign y_out     = y_sn[N];

endmodule

FILE: design/rap_scale.sv
// ----------------------------------------------------------------------------
// rap_scale
// Scales cos and sin by the radius, rounds and offsets from the centre.
// ----------------------------------------------------------------------------
module rap_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_in,
	input  rap_pkg::side_t                    side_in,
	input  logic                              neg_in,
	input  logic signed [rap_pkg::XY_W-1:0]   x_in,
	input  logic signed [rap_pkg::XY_W-1:0]   y_in,
	output logic                              m_tvalid,
	output logic [rap_pkg::DATA_OUT_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	logic                            valid_s1, valid_s2, valid_s3;
	rap_pkg::side_t                  side_s1, side_s2, side_s3;
	logic signed [rap_pkg::XY_W-1:0] c_s1, s_s1;
	logic signed [65:0]              pc_s2, ps_s2;
	logic signed [35:0]              rc_s3, rs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			m_tvalid <= valid_s3;
		end
	end

	// Undo the fold, multiply, round, then subtract with saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			c_s1    <= neg_in ? -x_in : x_in;
			s_s1    <= neg_in ? -y_in : y_in;
			side_s2 <= side_s1;
			pc_s2   <= 66'(side_s1.r) * 66'(c_s1);
			ps_s2   <= 66'(side_s1.r) * 66'(s_s1);
			side_s3 <= side_s2;
			rc_s3   <= 36'((pc_s2 + 66'sd536870912) >>> 30);
			rs_s3   <= 36'((ps_s2 + 66'sd536870912) >>> 30);
			m_tdata <= {6'd0, side_s3.idx, side_s3.ang, side_s3.z,
				rap_pkg::sat32(40'(side_s3.cy) - 40'(rs_s3)),
				rap_pkg::sat32(40'(side_s3.cx) - 40'(rc_s3))};
			m_tlast <= side_s3.last;
		end
	end

endmodule

FILE: design/ring_armor_positions_core.sv
// An accepted target holds the input side until its last plate has been
// issued, and does not hold it when the count is zero: the issue stage hands
// out one plate per cycle after the accepting beat while the output is not
// stalled, and a new target is taken on the cycle after the last plate
// has left it. Each plate then runs 38 more register stages (angle wrap,
// quadrant fold, 28 CORDIC rotations, multiply and round) before it shows at
// the output. A stall at the output freezes the whole pipeline without loss.
// ----------------------------------------------------------------------------
// ring_armor_positions_core
// Positions of the armor plates on a ring around a target.
// ----------------------------------------------------------------------------
module ring_armor_positions_core #(
	parameter int MAX_ARMORS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// center_x, center_y, center_z, yaw_angle, base_radius, radius_offset,
	// height_offset, plate_count; zero padded
	input  logic [rap_pkg::DATA_IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// plate_x, plate_y, plate_z, plate_angle, plate_index; zero padded
	output logic [rap_pkg::DATA_OUT_W-1:0]  m_tdata,
	output logic                            m_tlast
);

	logic                              en;
	logic                              valid_s1;
	rap_pkg::side_t                    side_s1;
	logic signed [rap_pkg::ANG_W-1:0]  ang_s1;
	logic                              c_valid;
	rap_pkg::side_t                    c_side;
	logic                              c_neg;
	logic signed [rap_pkg::XY_W-1:0]   c_x, c_y;

	// The pipeline moves whenever the output beat is free or taken.
	assign en = !m_tvalid || m_tready;

	rap_issue #(.MAX_ARMORS(MAX_ARMORS)) u_issue (
		.clk(clk), .arst_n(arst_n), .en(en),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.valid_s1(valid_s1), .side_s1(side_s1), .ang_s1(ang_s1)
	);

	rap_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_in(valid_s1), .side_in(side_s1), .ang_in(ang_s1),
		.valid_out(c_valid), .side_out(c_side), .neg_out(c_neg),
		.x_out(c_x), .y_out(c_y)
	);

	rap_scale u_scale (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_in(c_valid), .side_in(c_side), .neg_in(c_neg),
		.x_in(c_x), .y_in(c_y),
		.m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

endmodule

FILE: design/rap_checker.sv
// ----------------------------------------------------------------------------
// rap_checker
// Port-level checks of the ring armor position core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rap_checker #(
	parameter int MAX_ARMORS = 8
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [rap_pkg::DATA_IN_W-1:0]   s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rap_pkg::DATA_OUT_W-1:0]  m_tdata,
	input logic                            m_tlast
);

	// A stalled beat stays offered.
	`RAP_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	// A stalled beat keeps its payload.
	`RAP_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// A target with no plates leaves the input free.
	`RAP_ASSERT_NEXT(a_zero_idle, s_tvalid && s_tready && s_tdata[226:223] == 4'd0, s_tready)
	// Plate numbers stay within the ring.
	`RAP_ASSERT_IMPL(a_index_range, m_tvalid, 32'(m_tdata[129:127]) < MAX_ARMORS)

endmodule

bind ring_armor_positions_core rap_checker #(.MAX_ARMORS(MAX_ARMORS)) u_rap_checker (.*);
